// ===== hw/rtl/tsb_pkg.sv =====
// shared types, constants and helper functions for the texture sampler
package tsb_pkg;

    // texel store geometry
    localparam int MAX_TEXELS = 65536;
    localparam int ADDR_W     = $clog2(MAX_TEXELS);
    localparam int MAX_DIM    = 256;
    localparam int DIM_W      = 9;
    localparam int POS_W      = $clog2(MAX_DIM);

    // fixed point formats
    localparam int COORD_IN_W = 18;
    localparam int COORD_W    = 17;
    localparam int FRAC_W     = 16;
    localparam int CHAN_W     = 8;
    localparam int RES_W      = 16;
    localparam int TOP_W      = CHAN_W + FRAC_W;
    localparam int ACC_W      = TOP_W + COORD_W;

    localparam logic [COORD_W-1:0] ONE_Q16     = 17'h10000;
    localparam logic [RES_W-1:0]   MAGENTA_Q88 = 16'hFF00;

    // request codes
    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    // configuration register indexes
    localparam logic [1:0] CFG_TEX_WIDTH       = 2'd0;
    localparam logic [1:0] CFG_TEX_HEIGHT      = 2'd1;
    localparam logic [1:0] CFG_FILTER_MODE     = 2'd2;
    localparam logic [1:0] CFG_TEXTURE_PRESENT = 2'd3;

    typedef logic [3*CHAN_W-1:0] texel_t;

    // blend pipeline stage enables
    typedef struct packed {
        logic s1_en;
        logic s2_en;
    } blend_ctrl_t;

    // effective dimension minus one: zero acts as one, large values saturate
    function automatic logic [POS_W-1:0] dim_minus_one(input logic [DIM_W-1:0] d);
        logic [POS_W-1:0] r;
        if (d == '0)
        begin
            r = '0;
        end
        else if (d > DIM_W'(MAX_DIM))
        begin
            r = POS_W'(MAX_DIM - 1);
        end
        else
        begin
            r = POS_W'(d - DIM_W'(1));
        end
        return r;
    endfunction

    // saturate a signed q2.16 coordinate to 0..1.0
    function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_IN_W-1:0] c);
        logic [COORD_W-1:0] r;
        if (c[COORD_IN_W-1])
        begin
            r = '0;
        end
        else if (c[COORD_IN_W-2:0] > ONE_Q16)
        begin
            r = ONE_Q16;
        end
        else
        begin
            r = c[COORD_IN_W-2:0];
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/tsb_texmem.sv =====
// single-port synchronous texel memory with a registered read
module tsb_texmem
(
    input  logic                       clk,
    input  logic                       we,
    input  logic                       re,
    input  logic [tsb_pkg::ADDR_W-1:0] addr,
    input  tsb_pkg::texel_t            wdata,
    output tsb_pkg::texel_t            rdata
);

    tsb_pkg::texel_t mem [tsb_pkg::MAX_TEXELS];
    tsb_pkg::texel_t rdata_reg;

    // write or registered read on the one port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        else if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/tsb_blend.sv =====
// two-stage bilinear blend of four texels, one lane per color channel
module tsb_blend
(
    input  logic                          clk,
    input  tsb_pkg::blend_ctrl_t          ctrl,
    input  tsb_pkg::texel_t               c00,
    input  tsb_pkg::texel_t               c10,
    input  tsb_pkg::texel_t               c01,
    input  tsb_pkg::texel_t               c11,
    input  logic [tsb_pkg::COORD_W-1:0]   wx0,
    input  logic [tsb_pkg::FRAC_W-1:0]    wx1,
    input  logic [tsb_pkg::COORD_W-1:0]   wy0,
    input  logic [tsb_pkg::FRAC_W-1:0]    wy1,
    output logic [tsb_pkg::RES_W-1:0]     red,
    output logic [tsb_pkg::RES_W-1:0]     green,
    output logic [tsb_pkg::RES_W-1:0]     blue
);

    localparam int CW = tsb_pkg::CHAN_W;
    localparam int TW = tsb_pkg::TOP_W;
    localparam int AW = tsb_pkg::ACC_W;
    localparam int PW = TW + 1;
    localparam int QW = AW + 1;

    logic [tsb_pkg::RES_W-1:0] res [3];

    for (genvar ch = 0; ch < 3; ch++)
    begin : g_lane
        localparam int HI = 3*CW - 1 - CW*ch;

        logic [PW-1:0] p00, p10, p01, p11;
        logic [PW-1:0] top_sum, bot_sum;
        logic [TW-1:0] top_reg, bot_reg;
        logic [QW-1:0] qt, qb, acc_sum;
        logic [tsb_pkg::RES_W-1:0] res_reg;

        // horizontal blend of the two rows
        assign p00 = {{(PW-CW){1'b0}}, c00[HI -: CW]} * {{(PW-tsb_pkg::COORD_W){1'b0}}, wx0};
        assign p10 = {{(PW-CW){1'b0}}, c10[HI -: CW]} * {{(PW-tsb_pkg::FRAC_W){1'b0}}, wx1};
        assign p01 = {{(PW-CW){1'b0}}, c01[HI -: CW]} * {{(PW-tsb_pkg::COORD_W){1'b0}}, wx0};
        assign p11 = {{(PW-CW){1'b0}}, c11[HI -: CW]} * {{(PW-tsb_pkg::FRAC_W){1'b0}}, wx1};
        assign top_sum = p00 + p10;
        assign bot_sum = p01 + p11;

        // vertical blend and final truncation to q8.8
        assign qt = {{(QW-TW){1'b0}}, top_reg} * {{(QW-tsb_pkg::COORD_W){1'b0}}, wy0};
        assign qb = {{(QW-TW){1'b0}}, bot_reg} * {{(QW-tsb_pkg::FRAC_W){1'b0}}, wy1};
        assign acc_sum = qt + qb;

        always_ff @(posedge clk)
        begin
            if (ctrl.s1_en)
            begin
                top_reg <= top_sum[TW-1:0];
                bot_reg <= bot_sum[TW-1:0];
            end
            if (ctrl.s2_en)
            begin
                res_reg <= acc_sum[AW-2 -: tsb_pkg::RES_W];
            end
        end

        assign res[ch] = res_reg;
    end

    assign red   = res[0];
    assign green = res[1];
    assign blue  = res[2];

endmodule

// ===== hw/rtl/texture_sampler_bilinear.sv =====
// textured samples step through S_MUL, S_IDX, S_READ, S_LAST, S_BL1, S_BL2 to S_OUT
// without texture a sample goes straight to S_OUT; requests stall until back in S_IDLE
// one texel write per cycle in S_IDLE; bilinear's four reads use the one port in turn
// reset clears control and config (width 1, height 1, nearest, no texture)
// the texel memory is not cleared and holds undefined data until written
module texture_sampler_bilinear
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration port
    input  logic                                  cfg_we,
    input  logic [1:0]                            cfg_index,
    input  logic [tsb_pkg::DIM_W-1:0]             cfg_data,
    // request channel
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  req_type,
    input  logic [15:0]                           texel_addr,
    input  logic [7:0]                            texel_red,
    input  logic [7:0]                            texel_green,
    input  logic [7:0]                            texel_blue,
    input  logic signed [17:0]                    u_coord,
    input  logic signed [17:0]                    v_coord,
    // result channel
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [15:0]                           out_red,
    output logic [15:0]                           out_green,
    output logic [15:0]                           out_blue
);

    localparam int AW  = tsb_pkg::ADDR_W;
    localparam int PW  = tsb_pkg::POS_W;
    localparam int DW  = tsb_pkg::DIM_W;
    localparam int CW  = tsb_pkg::COORD_W;
    localparam int FW  = tsb_pkg::FRAC_W;
    localparam int QW  = CW + PW;
    localparam int XW  = PW + FW;
    localparam int BW  = PW + DW;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_IDX,
        S_READ,
        S_LAST,
        S_BL1,
        S_BL2,
        S_OUT
    } state_t;

    // configuration registers
    logic [DW-1:0] tex_width_reg, tex_height_reg;
    logic          filter_mode_reg, texture_present_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tex_width_reg       <= DW'(1);
            tex_height_reg      <= DW'(1);
            filter_mode_reg     <= 1'b0;
            texture_present_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tsb_pkg::CFG_TEX_WIDTH:       tex_width_reg       <= cfg_data;
                tsb_pkg::CFG_TEX_HEIGHT:      tex_height_reg      <= cfg_data;
                tsb_pkg::CFG_FILTER_MODE:     filter_mode_reg     <= cfg_data[0];
                tsb_pkg::CFG_TEXTURE_PRESENT: texture_present_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // effective dimensions
    logic [PW-1:0] wm1, hm1;
    logic [DW-1:0] w_eff;

    assign wm1   = tsb_pkg::dim_minus_one(tex_width_reg);
    assign hm1   = tsb_pkg::dim_minus_one(tex_height_reg);
    assign w_eff = {1'b0, wm1} + DW'(1);

    // control state
    state_t      state_reg, state_next;
    logic [1:0]  k_reg, k_next;
    logic        rd_pend_reg;
    logic [1:0]  rd_slot_reg;
    logic        out_valid_reg, out_valid_next;

    // payload registers
    logic [CW-1:0] u_reg, vinv_reg;
    logic          bilinear_reg, magenta_reg;
    logic [XW-1:0] xq_reg, yq_reg;
    logic [PW-1:0] x0_reg, x1_reg;
    logic [AW-1:0] base0_reg, base1_reg;
    logic [CW-1:0] wx0_reg, wy0_reg;
    logic [FW-1:0] wx1_reg, wy1_reg;
    tsb_pkg::texel_t tex_reg [4];
    logic [15:0]   out_red_reg, out_green_reg, out_blue_reg;

    logic in_fire, wr_fire, sample_fire, out_free, last_read;

    assign in_fire     = in_valid && !in_stall;
    assign wr_fire     = in_fire && (req_type == tsb_pkg::REQ_WRITE);
    assign sample_fire = in_fire && (req_type == tsb_pkg::REQ_SAMPLE);
    assign out_free    = !out_valid_reg || !out_stall;
    assign last_read   = !bilinear_reg || (k_reg == 2'd3);
    assign in_stall    = (state_reg != S_IDLE);

    // next state
    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (sample_fire)
                begin
                    state_next = texture_present_reg ? S_MUL : S_OUT;
                end
            end
            S_MUL:  state_next = S_IDX;
            S_IDX:
            begin
                state_next = S_READ;
                k_next     = 2'd0;
            end
            S_READ:
            begin
                k_next = k_reg + 2'd1;
                if (last_read)
                begin
                    state_next = S_LAST;
                end
            end
            S_LAST: state_next = S_BL1;
            S_BL1:  state_next = S_BL2;
            S_BL2:  state_next = S_OUT;
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // result beat hand-off
    always_comb
    begin
        if (state_reg == S_OUT && out_free)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            k_reg         <= 2'd0;
            rd_pend_reg   <= 1'b0;
            rd_slot_reg   <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            rd_pend_reg   <= (state_reg == S_READ);
            rd_slot_reg   <= k_reg;
            out_valid_reg <= out_valid_next;
        end
    end

    // coordinate scaling
    logic [QW-1:0] xq_full, yq_full;

    assign xq_full = {{PW{1'b0}}, u_reg} * {{CW{1'b0}}, wm1};
    assign yq_full = {{PW{1'b0}}, vinv_reg} * {{CW{1'b0}}, hm1};

    // edge clamp and row base addresses
    logic [PW-1:0] x0, y0, x1, y1;
    logic [BW-1:0] base0_full, base1_full;

    assign x0 = xq_reg[XW-1:FW];
    assign y0 = yq_reg[XW-1:FW];
    assign x1 = (x0 == wm1) ? x0 : x0 + PW'(1);
    assign y1 = (y0 == hm1) ? y0 : y0 + PW'(1);
    assign base0_full = {{DW{1'b0}}, y0} * {{PW{1'b0}}, w_eff};
    assign base1_full = {{DW{1'b0}}, y1} * {{PW{1'b0}}, w_eff};

    // texel memory port
    logic            mem_we, mem_re;
    logic [AW-1:0]   mem_addr, rd_addr;
    tsb_pkg::texel_t mem_wdata, mem_rdata;

    assign rd_addr   = (k_reg[1] ? base1_reg : base0_reg)
                     + {{(AW-PW){1'b0}}, (k_reg[0] ? x1_reg : x0_reg)};
    assign mem_we    = (state_reg == S_IDLE) && wr_fire;
    assign mem_re    = (state_reg == S_READ);
    assign mem_addr  = mem_we ? texel_addr[AW-1:0] : rd_addr;
    assign mem_wdata = {texel_red, texel_green, texel_blue};

    tsb_texmem u_texmem
    (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // blend datapath
    tsb_pkg::blend_ctrl_t blend_ctrl;
    logic [15:0] bl_red, bl_green, bl_blue;

    assign blend_ctrl.s1_en = (state_reg == S_BL1);
    assign blend_ctrl.s2_en = (state_reg == S_BL2);

    tsb_blend u_blend
    (
        .clk   (clk),
        .ctrl  (blend_ctrl),
        .c00   (tex_reg[0]),
        .c10   (tex_reg[1]),
        .c01   (tex_reg[2]),
        .c11   (tex_reg[3]),
        .wx0   (wx0_reg),
        .wx1   (wx1_reg),
        .wy0   (wy0_reg),
        .wy1   (wy1_reg),
        .red   (bl_red),
        .green (bl_green),
        .blue  (bl_blue)
    );

    // sample datapath registers
    always_ff @(posedge clk)
    begin
        if (sample_fire)
        begin
            u_reg        <= tsb_pkg::clamp_coord(u_coord);
            vinv_reg     <= tsb_pkg::ONE_Q16 - tsb_pkg::clamp_coord(v_coord);
            bilinear_reg <= filter_mode_reg;
            magenta_reg  <= !texture_present_reg;
        end
        if (state_reg == S_MUL)
        begin
            xq_reg <= xq_full[XW-1:0];
            yq_reg <= yq_full[XW-1:0];
        end
        if (state_reg == S_IDX)
        begin
            x0_reg    <= x0;
            x1_reg    <= x1;
            base0_reg <= base0_full[AW-1:0];
            base1_reg <= base1_full[AW-1:0];
            // nearest mode puts all weight on the first texel
            if (bilinear_reg)
            begin
                wx0_reg <= tsb_pkg::ONE_Q16 - {1'b0, xq_reg[FW-1:0]};
                wx1_reg <= xq_reg[FW-1:0];
                wy0_reg <= tsb_pkg::ONE_Q16 - {1'b0, yq_reg[FW-1:0]};
                wy1_reg <= yq_reg[FW-1:0];
            end
            else
            begin
                wx0_reg <= tsb_pkg::ONE_Q16;
                wx1_reg <= '0;
                wy0_reg <= tsb_pkg::ONE_Q16;
                wy1_reg <= '0;
            end
        end
        if (rd_pend_reg)
        begin
            tex_reg[rd_slot_reg] <= mem_rdata;
        end
        if (state_reg == S_OUT && out_free)
        begin
            if (magenta_reg)
            begin
                out_red_reg   <= tsb_pkg::MAGENTA_Q88;
                out_green_reg <= '0;
                out_blue_reg  <= tsb_pkg::MAGENTA_Q88;
            end
            else if (!bilinear_reg)
            begin
                // nearest takes the one texel read; the other slots are not loaded in nearest mode
                out_red_reg   <= {tex_reg[0][23:16], 8'h00};
                out_green_reg <= {tex_reg[0][15:8], 8'h00};
                out_blue_reg  <= {tex_reg[0][7:0], 8'h00};
            end
            else
            begin
                out_red_reg   <= bl_red;
                out_green_reg <= bl_green;
                out_blue_reg  <= bl_blue;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_red   = out_red_reg;
    assign out_green = out_green_reg;
    assign out_blue  = out_blue_reg;

    // memory port is never asked for a read and a write together
    assert property (@(posedge clk) disable iff (!rst_n) !(mem_we && mem_re))
        else $error("texel memory read and write in the same cycle");

    // an accepted sample blocks the request channel on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n) sample_fire |=> in_stall)
        else $error("request channel open right after a sample beat");

    // a new result beat only appears out of the output state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == S_OUT))
        else $error("result beat raised outside the output state");

    // neighbor columns stay inside the texture while reading
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> (x1_reg <= wm1 && x0_reg <= x1_reg))
        else $error("texel column outside the clamped range");

endmodule
